FILE: rtl/satc_pkg.sv
package satc_pkg;

    localparam int WORD_W  = 32;
    localparam int ALPHA_W = 17;
    localparam int ATAN_N  = 24;

    // Index of each configuration register on the write port.
    localparam logic [1:0] REG_X_IDX     = 2'd0;
    localparam logic [1:0] REG_Y_IDX     = 2'd1;
    localparam logic [1:0] REG_ALPHA_IDX = 2'd2;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    typedef struct packed {
        logic signed [31:0] parent_a;
        logic signed [31:0] parent_b;
        logic signed [31:0] parent_c;
        logic signed [31:0] parent_d;
        logic signed [31:0] parent_tx;
        logic signed [31:0] parent_ty;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] own_scale_x;
        logic signed [31:0] own_scale_y;
        logic signed [31:0] rotation_deg;
        logic [16:0]        parent_alpha;
    } satc_in_t;

    typedef struct packed {
        logic signed [31:0] out_a;
        logic signed [31:0] out_b;
        logic signed [31:0] out_c;
        logic signed [31:0] out_d;
        logic signed [31:0] out_tx;
        logic signed [31:0] out_ty;
        logic [16:0]        out_alpha;
    } satc_out_t;

    // Arctangent of 2^-i in degrees, Q24.
    function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
        logic signed [31:0] v;
        unique case (i)
            5'd0: v = 32'sd754974720;  5'd1: v = 32'sd445687602;
            5'd2: v = 32'sd235489088;  5'd3: v = 32'sd119537938;
            5'd4: v = 32'sd60000934;   5'd5: v = 32'sd30029717;
            5'd6: v = 32'sd15018523;   5'd7: v = 32'sd7509720;
            5'd8: v = 32'sd3754917;    5'd9: v = 32'sd1877466;
            5'd10: v = 32'sd938734;    5'd11: v = 32'sd469367;
            5'd12: v = 32'sd234684;    5'd13: v = 32'sd117342;
            5'd14: v = 32'sd58671;     5'd15: v = 32'sd29335;
            5'd16: v = 32'sd14668;     5'd17: v = 32'sd7334;
            5'd18: v = 32'sd3667;      5'd19: v = 32'sd1833;
            5'd20: v = 32'sd917;       5'd21: v = 32'sd458;
            5'd22: v = 32'sd229;       5'd23: v = 32'sd115;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Saturates a wide signed value into 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
        logic signed [31:0] r;
        if (v > 80'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -80'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/satc_cordic.sv
module satc_cordic
    import satc_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16,
    parameter int TAG_W        = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [31:0]       in_rot,
    input  logic [TAG_W-1:0]         in_tag,
    output logic                     out_valid,
    output logic signed [31:0]       out_cos,
    output logic signed [31:0]       out_sin,
    output logic [TAG_W-1:0]         out_tag
);

    localparam int NSTEP = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;
    localparam logic signed [47:0] FULL   = 48'sd360 <<< FRAC_BITS;
    localparam logic signed [47:0] DEG90  = 48'sd90 <<< 24;
    localparam logic signed [47:0] DEG180 = 48'sd180 <<< 24;
    localparam int RSH = 30 - FRAC_BITS;

    // Stage A: angle reduction. Remainder by 360 via floor estimate using a
    // reciprocal multiply, then one or two correction steps.
    localparam int RECIP_SH = 40;
    localparam logic signed [63:0] RECIP =
        64'((64'd1 << RECIP_SH) / 64'(FULL) + 64'd1);

    logic                    a_valid_reg;
    logic signed [47:0]      a_rot_reg;
    logic signed [47:0]      a_q_reg;
    logic [TAG_W-1:0]        a_tag_reg;
    logic signed [63:0]      q_prod;
    logic signed [47:0]      q_est;

    always_comb begin
        q_prod = 64'(in_rot) * RECIP;
        q_est  = 48'(q_prod >>> RECIP_SH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
        if (en) begin
            a_rot_reg <= 48'(in_rot);
            a_q_reg   <= q_est;
            a_tag_reg <= in_tag;
        end
    end

    // Stage B: finish the remainder and fold into [-90, 90].
    logic                    b_valid_reg;
    logic signed [47:0]      b_z_reg;
    logic                    b_flip_reg;
    logic [TAG_W-1:0]        b_tag_reg;
    logic signed [47:0]      r0;
    logic signed [47:0]      zz;
    logic                    flip;

    always_comb begin
        r0 = a_rot_reg - 48'(a_q_reg * FULL);
        if (r0 < 0) begin
            r0 = r0 + FULL;
        end
        if (r0 < 0) begin
            r0 = r0 + FULL;
        end
        if (r0 >= FULL) begin
            r0 = r0 - FULL;
        end
        zz = r0 <<< (24 - FRAC_BITS);
        flip = 1'b0;
        if (zz >= DEG180) begin
            zz = zz - (DEG180 <<< 1);
        end
        if (zz > DEG90) begin
            zz = zz - DEG180;
            flip = 1'b1;
        end else if (zz < -DEG90) begin
            zz = zz + DEG180;
            flip = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
        if (en) begin
            b_z_reg    <= zz;
            b_flip_reg <= flip;
            b_tag_reg  <= a_tag_reg;
        end
    end

    // One register stage per CORDIC iteration.
    logic                 s_valid_reg [1:NSTEP];
    logic signed [35:0]   s_x_reg     [1:NSTEP];
    logic signed [35:0]   s_y_reg     [1:NSTEP];
    logic signed [35:0]   s_z_reg     [1:NSTEP];
    logic                 s_flip_reg  [1:NSTEP];
    logic [TAG_W-1:0]     s_tag_reg   [1:NSTEP];

    for (genvar i = 0; i < NSTEP; i++) begin : g_step
        logic               v_in;
        logic signed [35:0] x_in;
        logic signed [35:0] y_in;
        logic signed [35:0] z_in;
        logic               f_in;
        logic [TAG_W-1:0]   t_in;
        logic signed [35:0] dx;
        logic signed [35:0] dy;
        logic signed [35:0] at;
        if (i == 0) begin : g_first
            assign v_in = b_valid_reg;
            assign x_in = 36'(CORDIC_GAIN);
            assign y_in = 36'sd0;
            assign z_in = b_z_reg[35:0];
            assign f_in = b_flip_reg;
            assign t_in = b_tag_reg;
        end else begin : g_next
            assign v_in = s_valid_reg[i];
            assign x_in = s_x_reg[i];
            assign y_in = s_y_reg[i];
            assign z_in = s_z_reg[i];
            assign f_in = s_flip_reg[i];
            assign t_in = s_tag_reg[i];
        end
        assign dx = y_in >>> i;
        assign dy = x_in >>> i;
        assign at = 36'(atan_deg(5'(i)));
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                s_valid_reg[i+1] <= 1'b0;
            end else if (en) begin
                s_valid_reg[i+1] <= v_in;
            end
            if (en) begin
                if (!z_in[35]) begin
                    s_x_reg[i+1] <= x_in - dx;
                    s_y_reg[i+1] <= y_in + dy;
                    s_z_reg[i+1] <= z_in - at;
                end else begin
                    s_x_reg[i+1] <= x_in + dx;
                    s_y_reg[i+1] <= y_in - dy;
                    s_z_reg[i+1] <= z_in + at;
                end
                s_flip_reg[i+1] <= f_in;
                s_tag_reg[i+1]  <= t_in;
            end
        end
    end

    logic signed [35:0] xr;
    logic signed [35:0] yr;
    always_comb begin
        xr = (s_x_reg[NSTEP] + (36'sd1 <<< (RSH - 1))) >>> RSH;
        yr = (s_y_reg[NSTEP] + (36'sd1 <<< (RSH - 1))) >>> RSH;
        if (s_flip_reg[NSTEP]) begin
            xr = -xr;
            yr = -yr;
        end
    end

    assign out_valid = s_valid_reg[NSTEP];
    assign out_cos   = xr[31:0];
    assign out_sin   = yr[31:0];
    assign out_tag   = s_tag_reg[NSTEP];

endmodule

FILE: rtl/sprite_affine_transform_compose.sv
// Sprite transform composer. Each request carries a parent 2x3 affine matrix,
// the sprite's position, scales, rotation in degrees and parent alpha; the
// block returns the combined matrix and alpha. It accepts one request per
// cycle while the result side is not stalled. Its pipeline is two stages of
// angle reduction, one register stage per CORDIC iteration (up to 24), then
// four stages of products and sums for the matrix concatenation, set by the
// chain of dependent 32x32 multiplies. The whole pipeline advances whenever
// the output register is empty or being taken, so a stall at the result
// side freezes every stage and nothing is lost. Configuration writes take
// effect on the next request and must be issued only while the block is
// idle.
module sprite_affine_transform_compose
    import satc_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  satc_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output satc_out_t   m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int NSTEP = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;
    localparam int CLAT  = NSTEP + 2;
    localparam logic signed [79:0] HALF = 80'sd1 <<< (FRAC_BITS - 1);

    logic signed [31:0] reg_x_reg;
    logic signed [31:0] reg_y_reg;
    logic [16:0]        alpha_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reg_x_reg <= '0;
            reg_y_reg <= '0;
            alpha_reg <= ALPHA_ONE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_X_IDX:     reg_x_reg <= cfg_data;
                REG_Y_IDX:     reg_y_reg <= cfg_data;
                REG_ALPHA_IDX: alpha_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // Global advance: every stage moves when the output slot is empty or being taken.
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Request payload rides along the CORDIC in a delay line.
    satc_in_t d_reg [1:CLAT];
    for (genvar k = 1; k <= CLAT; k++) begin : g_dly
        satc_in_t d_next;
        if (k == 1) begin : g_head
            assign d_next = s_data;
        end else begin : g_tail
            assign d_next = d_reg[k-1];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[k] <= d_next;
            end
        end
    end

    logic               c_valid;
    logic signed [31:0] c_cos;
    logic signed [31:0] c_sin;
    logic               c_tag;

    satc_cordic #(
        .FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS), .TAG_W(1)
    ) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid), .in_rot(s_data.rotation_deg), .in_tag(1'b0),
        .out_valid(c_valid), .out_cos(c_cos), .out_sin(c_sin), .out_tag(c_tag)
    );

    function automatic logic signed [79:0] mq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
        logic signed [79:0] p;
        p = 80'(a) * 80'(b);
        return (p + HALF) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] a);
        return sat32(-80'(a));
    endfunction

    satc_in_t q;
    assign q = d_reg[CLAT];

    // Stage 1: local matrix.
    logic p1_v_reg;
    satc_in_t p1_d_reg;
    logic signed [31:0] la_reg, lb_reg, lc_reg, ld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) p1_v_reg <= 1'b0;
        else if (en) p1_v_reg <= c_valid & ~c_tag;
        if (en) begin
            p1_d_reg <= q;
            la_reg <= sat32(mq(q.own_scale_x, c_cos));
            lb_reg <= sat32(mq(q.own_scale_x, c_sin));
            lc_reg <= sat32(mq(q.own_scale_y, neg_sat(c_sin)));
            ld_reg <= sat32(mq(q.own_scale_y, c_cos));
        end
    end

    // Stage 2: partial products of the concatenation and of the position.
    logic p2_v_reg;
    satc_in_t p2_d_reg;
    logic signed [79:0] m_al_reg, m_cb_reg, m_alc_reg, m_cld_reg;
    logic signed [79:0] m_bla_reg, m_dlb_reg, m_blc_reg, m_dld_reg;
    logic signed [79:0] tx0_reg, ty0_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) p2_v_reg <= 1'b0;
        else if (en) p2_v_reg <= p1_v_reg;
        if (en) begin
            p2_d_reg  <= p1_d_reg;
            m_al_reg  <= mq(p1_d_reg.parent_a, la_reg);
            m_cb_reg  <= mq(p1_d_reg.parent_c, lb_reg);
            m_alc_reg <= mq(p1_d_reg.parent_a, lc_reg);
            m_cld_reg <= mq(p1_d_reg.parent_c, ld_reg);
            m_bla_reg <= mq(p1_d_reg.parent_b, la_reg);
            m_dlb_reg <= mq(p1_d_reg.parent_d, lb_reg);
            m_blc_reg <= mq(p1_d_reg.parent_b, lc_reg);
            m_dld_reg <= mq(p1_d_reg.parent_d, ld_reg);
            tx0_reg <= mq(p1_d_reg.parent_a, p1_d_reg.pos_x)
                     + mq(p1_d_reg.parent_c, p1_d_reg.pos_y)
                     + 80'(p1_d_reg.parent_tx);
            ty0_reg <= mq(p1_d_reg.parent_b, p1_d_reg.pos_x)
                     + mq(p1_d_reg.parent_d, p1_d_reg.pos_y)
                     + 80'(p1_d_reg.parent_ty);
        end
    end

    // Stage 3: combined linear part, registration-point products, alpha.
    logic p3_v_reg;
    logic signed [31:0] oa_reg, ob_reg, oc_reg, od_reg;
    logic signed [79:0] tx1_reg, ty1_reg;
    logic [16:0] al_reg;
    logic [33:0] al_prod;
    logic [33:0] al_rnd;
    assign al_prod = 34'(p2_d_reg.parent_alpha) * 34'(alpha_reg);
    assign al_rnd  = (al_prod + 34'd32768) >> 16;
    always_ff @(posedge aclk) begin
        if (!aresetn) p3_v_reg <= 1'b0;
        else if (en) p3_v_reg <= p2_v_reg;
        if (en) begin
            oa_reg <= sat32(m_al_reg + m_cb_reg);
            oc_reg <= sat32(m_alc_reg + m_cld_reg);
            ob_reg <= sat32(m_bla_reg + m_dlb_reg);
            od_reg <= sat32(m_blc_reg + m_dld_reg);
            tx1_reg <= tx0_reg + mq(p2_d_reg.parent_a, reg_x_reg)
                     + mq(p2_d_reg.parent_c, reg_y_reg);
            ty1_reg <= ty0_reg + mq(p2_d_reg.parent_b, reg_x_reg)
                     + mq(p2_d_reg.parent_d, reg_y_reg);
            al_reg <= (al_rnd > 34'(ALPHA_ONE)) ? ALPHA_ONE : al_rnd[16:0];
        end
    end

    // Stage 4: subtract the rotated registration point, saturate.
    wire signed [79:0] nrx_w = -80'(reg_x_reg);
    wire signed [79:0] nry_w = -80'(reg_y_reg);

    function automatic logic signed [79:0] mqw(input logic signed [31:0] a,
                                               input logic signed [79:0] b);
        logic signed [79:0] p;
        p = 80'(a) * b;
        return (p + HALF) >>> FRAC_BITS;
    endfunction

    satc_out_t out_reg;
    logic      out_v_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) out_v_reg <= 1'b0;
        else if (en) out_v_reg <= p3_v_reg;
        if (en) begin
            out_reg.out_a  <= oa_reg;
            out_reg.out_b  <= ob_reg;
            out_reg.out_c  <= oc_reg;
            out_reg.out_d  <= od_reg;
            out_reg.out_tx <= sat32(tx1_reg + mqw(oa_reg, nrx_w) + mqw(oc_reg, nry_w));
            out_reg.out_ty <= sat32(ty1_reg + mqw(ob_reg, nrx_w) + mqw(od_reg, nry_w));
            out_reg.out_alpha <= al_reg;
        end
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

    // A result held while stalled keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed under stall");
    a_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.out_alpha <= ALPHA_ONE)
        else $error("alpha above one");
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown(m_valid))
        else $error("result valid unknown");

endmodule

FILE: tb/satc_checker.sv
`timescale 1ns / 100ps

module satc_checker
    import satc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  satc_in_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  satc_out_t   m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    localparam int FRAC = 16;
    localparam int STEPS = 16;

    longint    reg_x_q;
    longint    reg_y_q;
    longint    alpha_q;
    satc_out_t transform_q[$];

    assign pending = transform_q.size();

    function automatic longint rshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return rnd(a * b, FRAC);
    endfunction

    function automatic longint atan_entry(int i);
        longint t[24];
        t = '{754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
              15018523, 7509720, 3754917, 1877466, 938734, 469367,
              234684, 117342, 58671, 29335, 14668, 7334,
              3667, 1833, 917, 458, 229, 115};
        return t[i];
    endfunction

    function automatic satc_out_t compose(satc_in_t r);
        longint full, d90, d180, ang, z, x, y, dx, dy, cs, sn;
        longint la, lb, lc, ld, oa, ob, oc, od, tx, ty, al;
        longint pa, pb, pc, pd;
        bit flip;
        satc_out_t o;
        full = longint'(360) << FRAC;
        d90 = longint'(90) << 24;
        d180 = longint'(180) << 24;
        flip = 0;
        ang = longint'(r.rotation_deg) % full;
        if (ang < 0) ang += full;
        z = ang * (longint'(1) << (24 - FRAC));
        if (z >= d180) z -= 2 * d180;
        if (z > d90) begin
            z -= d180;
            flip = 1;
        end else if (z < -d90) begin
            z += d180;
            flip = 1;
        end
        x = 652032874;
        y = 0;
        for (int i = 0; i < STEPS && i < 24; i++) begin
            dx = rshift(y, i);
            dy = rshift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_entry(i);
            end else begin
                x += dx; y -= dy; z += atan_entry(i);
            end
        end
        cs = rnd(x, 30 - FRAC);
        sn = rnd(y, 30 - FRAC);
        if (flip) begin
            cs = -cs; sn = -sn;
        end
        la = clamp32(qmul(r.own_scale_x, cs));
        lb = clamp32(qmul(r.own_scale_x, sn));
        lc = clamp32(qmul(r.own_scale_y, -sn));
        ld = clamp32(qmul(r.own_scale_y, cs));
        pa = r.parent_a; pb = r.parent_b; pc = r.parent_c; pd = r.parent_d;
        oa = clamp32(qmul(pa, la) + qmul(pc, lb));
        oc = clamp32(qmul(pa, lc) + qmul(pc, ld));
        ob = clamp32(qmul(pb, la) + qmul(pd, lb));
        od = clamp32(qmul(pb, lc) + qmul(pd, ld));
        // Translation pivots about the registration point using the clamped matrix.
        tx = clamp32(qmul(pa, r.pos_x) + qmul(pc, r.pos_y) + longint'(r.parent_tx)
                     + qmul(pa, reg_x_q) + qmul(pc, reg_y_q)
                     + qmul(oa, -reg_x_q) + qmul(oc, -reg_y_q));
        ty = clamp32(qmul(pb, r.pos_x) + qmul(pd, r.pos_y) + longint'(r.parent_ty)
                     + qmul(pb, reg_x_q) + qmul(pd, reg_y_q)
                     + qmul(ob, -reg_x_q) + qmul(od, -reg_y_q));
        al = (longint'(r.parent_alpha) * alpha_q + 32768) >>> 16;
        if (al > 65536) al = 65536;
        o.out_a = oa[31:0]; o.out_b = ob[31:0]; o.out_c = oc[31:0];
        o.out_d = od[31:0]; o.out_tx = tx[31:0]; o.out_ty = ty[31:0];
        o.out_alpha = al[16:0];
        return o;
    endfunction

    always @(posedge aclk) begin
        satc_out_t want;
        if (!aresetn) begin
            reg_x_q <= 0;
            reg_y_q <= 0;
            alpha_q <= 65536;
            fail_count <= 0;
            transform_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_X_IDX) reg_x_q <= longint'($signed(cfg_data));
                else if (cfg_index == REG_Y_IDX) reg_y_q <= longint'($signed(cfg_data));
                else if (cfg_index == REG_ALPHA_IDX) alpha_q <= longint'(cfg_data[16:0]);
            end
            if (s_valid && s_ready) transform_q.push_back(compose(s_data));
            if (m_valid && m_ready) begin
                if (transform_q.size() == 0) begin
                    if (fail_count < 10) $display("ERROR: unexpected result %h", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = transform_q.pop_front();
                    if (want !== m_data) begin
                        if (fail_count < 10) begin
                            $display("ERROR: mismatch exp a=%h b=%h c=%h d=%h tx=%h ty=%h al=%h",
                                     want.out_a, want.out_b, want.out_c, want.out_d,
                                     want.out_tx, want.out_ty, want.out_alpha);
                            $display("       got     a=%h b=%h c=%h d=%h tx=%h ty=%h al=%h",
                                     m_data.out_a, m_data.out_b, m_data.out_c,
                                     m_data.out_d, m_data.out_tx, m_data.out_ty,
                                     m_data.out_alpha);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

// Testbench top for the sprite transform composer. It drives requests and
// configuration writes, applies random back-pressure on the result side and
// leaves all prediction and comparison to the checker instance.
module tb;
    import satc_pkg::*;

    localparam int LATENCY = 16 + 6;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    satc_in_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    satc_out_t   m_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          fail_count;
    int          pending;

    // Idle rates in percent for the sender and the receiver.
    int          send_idle = 27;
    int          recv_idle = 70;
    int          stall_count = 0;

    always #5 aclk = ~aclk;

    sprite_affine_transform_compose dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    satc_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // The receiver drops ready at random according to the current rate.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    // The watchdog ends the run if nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Picks a field value that is often an extreme and otherwise random.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h0001_0000;
            4: return 32'hFFFF_0000;
            5, 6: return $urandom;
            default: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    function automatic logic [16:0] pick_alpha();
        case ($urandom_range(4))
            0: return 17'd65536;
            1: return 17'd0;
            2: return 17'h1FFFF;
            default: return 17'($urandom);
        endcase
    endfunction

    function automatic satc_in_t random_request();
        satc_in_t r;
        r.parent_a = pick_word(); r.parent_b = pick_word();
        r.parent_c = pick_word(); r.parent_d = pick_word();
        r.parent_tx = pick_word(); r.parent_ty = pick_word();
        r.pos_x = pick_word(); r.pos_y = pick_word();
        r.own_scale_x = pick_word(); r.own_scale_y = pick_word();
        r.rotation_deg = ($urandom_range(3) == 0) ? $urandom
                       : $signed($urandom_range(720 * 65536)) - 32'sd23592960;
        r.parent_alpha = pick_alpha();
        return r;
    endfunction

    // Sends one request, idling beforehand at the sender's rate.
    task automatic send_request(input satc_in_t r);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Waits until every expected result has arrived, then lets the pipe drain.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // One write, followed by a deasserted write enable so that writes never overlap.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // A unit-matrix request with the given rotation, scales and alpha.
    function automatic satc_in_t unit_request(logic [31:0] rot, logic [31:0] sc,
                                              logic [16:0] al);
        satc_in_t r;
        r = '0;
        r.parent_a = 32'h0001_0000;
        r.parent_d = 32'h0001_0000;
        r.pos_x = 32'h0003_0000;
        r.pos_y = 32'hFFFE_0000;
        r.own_scale_x = sc;
        r.own_scale_y = sc;
        r.rotation_deg = rot;
        r.parent_alpha = al;
        return r;
    endfunction

    initial begin
        satc_in_t r;
        logic [31:0] angles[12];
        angles = '{32'h0, 32'h005A_0000, 32'h00B4_0000, 32'h010E_0000,
                   32'h0168_0000, 32'hFFA6_0000, 32'hFF4C_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h002D_8000, 32'h00B3_FFFF, 32'h0059_FFFF};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: special angles, alpha above one, and clamping matrices.
        for (int i = 0; i < 12; i++)
            send_request(unit_request(angles[i], 32'h0001_8000, 17'd65536));
        send_request(unit_request(32'h001E_0000, 32'h0001_0000, 17'h1FFFF));
        send_request(unit_request(32'h001E_0000, 32'h0001_0000, 17'd0));
        r = unit_request(32'h002D_0000, 32'h7FFF_FFFF, 17'd40000);
        r.parent_a = 32'h7FFF_FFFF; r.parent_c = 32'h7FFF_FFFF;
        r.parent_b = 32'h8000_0000; r.parent_d = 32'h8000_0000;
        send_request(r);
        r.own_scale_x = 32'h8000_0000; r.own_scale_y = 32'h7FFF_FFFF;
        r.parent_tx = 32'h7FFF_FFFF; r.parent_ty = 32'h8000_0000;
        send_request(r);
        r = '1;
        send_request(r);
        send_request('0);
        wait_idle();

        // Random part in phases, each under a new register setting.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_X_IDX, 32'h7FFF_FFFF);
                    write_reg(REG_Y_IDX, 32'h8000_0000);
                    write_reg(REG_ALPHA_IDX, 32'h0001_FFFF);
                end
                1: begin
                    write_reg(REG_X_IDX, 32'h0010_0000);
                    write_reg(REG_Y_IDX, 32'hFFF8_8000);
                    write_reg(REG_ALPHA_IDX, 32'd0);
                end
                2: begin
                    send_idle = 70; recv_idle = 27;
                    write_reg(REG_X_IDX, 32'h8000_0000);
                    write_reg(REG_Y_IDX, 32'h7FFF_FFFF);
                    write_reg(REG_ALPHA_IDX, 32'd32768);
                end
                3: begin
                    write_reg(REG_X_IDX, $urandom);
                    write_reg(REG_Y_IDX, $urandom);
                    write_reg(REG_ALPHA_IDX, $urandom);
                    write_reg(2'd3, $urandom);
                end
                4: begin
                    send_idle = 0; recv_idle = 0;
                    write_reg(REG_X_IDX, 32'h0000_8000);
                    write_reg(REG_Y_IDX, 32'h0002_0000);
                    write_reg(REG_ALPHA_IDX, 32'd65536);
                end
                default: begin
                    write_reg(REG_X_IDX, 32'd0);
                    write_reg(REG_Y_IDX, 32'd0);
                    write_reg(REG_ALPHA_IDX, 32'd54321);
                end
            endcase
            for (int n = 0; n < 92; n++) send_request(random_request());
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
